/* design/vmt_pkg.sv */
// ----------------------------------------------------------------------------
// vmt_pkg
// Types and constants shared by the virtio MMIO transport register block.
// ----------------------------------------------------------------------------
package vmt_pkg;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  reg_index;
        logic [31:0] write_value;
    } req_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic        irq_line;
        logic        notify_valid;
        logic [15:0] notify_queue;
    } rsp_t;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_EVENT = 2'd2;

    localparam logic [4:0] REG_MAGIC        = 5'd0;
    localparam logic [4:0] REG_VERSION      = 5'd1;
    localparam logic [4:0] REG_DEVICE_ID    = 5'd2;
    localparam logic [4:0] REG_DEV_FEAT     = 5'd3;
    localparam logic [4:0] REG_DEV_FEAT_SEL = 5'd4;
    localparam logic [4:0] REG_DRV_FEAT     = 5'd5;
    localparam logic [4:0] REG_DRV_FEAT_SEL = 5'd6;
    localparam logic [4:0] REG_QUEUE_SEL    = 5'd7;
    localparam logic [4:0] REG_QUEUE_MAX    = 5'd8;
    localparam logic [4:0] REG_QUEUE_SIZE   = 5'd9;
    localparam logic [4:0] REG_QUEUE_READY  = 5'd10;
    localparam logic [4:0] REG_QUEUE_NOTIFY = 5'd11;
    localparam logic [4:0] REG_IRQ_STATUS   = 5'd12;
    localparam logic [4:0] REG_IRQ_ACK      = 5'd13;
    localparam logic [4:0] REG_STATUS       = 5'd14;
    localparam logic [4:0] REG_DESC_BASE    = 5'd15;
    localparam logic [4:0] REG_AVAIL_BASE   = 5'd16;
    localparam logic [4:0] REG_USED_BASE    = 5'd17;

    localparam logic [1:0] CFG_DEVICE_TYPE = 2'd0;
    localparam logic [1:0] CFG_FEAT_LOW    = 2'd1;
    localparam logic [1:0] CFG_FEAT_HIGH   = 2'd2;
    localparam logic [1:0] CFG_QUEUE_LIMIT = 2'd3;

    localparam logic [31:0] MAGIC_WORD   = 32'h7472_6976;
    localparam logic [31:0] MMIO_VERSION = 32'd2;
    localparam int          STATUS_FEATURES_OK_BIT = 3;

    localparam logic [7:0]  DEVICE_TYPE_RESET = 8'd2;
    localparam logic [31:0] FEAT_LOW_RESET    = 32'd0;
    localparam logic [31:0] FEAT_HIGH_RESET   = 32'd1;
    localparam logic [15:0] QUEUE_LIMIT_RESET = 16'd256;

endpackage

/* design/virtio_mmio_transport_regs.sv */
// ----------------------------------------------------------------------------
// virtio_mmio_transport_regs
// Device-side register block of a virtio MMIO transport, version 2 layout.
// ----------------------------------------------------------------------------
// A request is taken on any cycle with start high; busy is always low, so one
// request per cycle is sustained. Each request is registered, decoded and
// applied in the following cycle. Its result appears on the result port with
// done high once it has passed the input register and the result register.
// The result is shown for one cycle only and cannot be stalled. Configuration
// writes are taken whenever no request sits in the input register.
module virtio_mmio_transport_regs
    import vmt_pkg::*;
#(
    parameter int QUEUE_COUNT = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        request,
    output logic        done,
    output rsp_t        result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam logic [16:0] QUEUE_LIMIT = 17'(QUEUE_COUNT);

    logic        req_valid_reg;
    req_t        req_reg;
    logic        done_reg;
    rsp_t        rsp_reg;
    rsp_t        rsp_next;

    logic [7:0]  device_type_reg;
    logic [31:0] feat_low_reg;
    logic [31:0] feat_high_reg;
    logic [15:0] queue_limit_reg;

    logic [7:0]  device_status_reg, device_status_next;
    logic [31:0] offer_page_reg, offer_page_next;
    logic [31:0] accepted_reg [2];
    logic [31:0] accepted_next [2];
    logic [31:0] accept_page_reg, accept_page_next;
    logic [15:0] selected_queue_reg, selected_queue_next;
    logic [15:0] ring_entries_reg [QUEUE_COUNT];
    logic [15:0] ring_entries_next [QUEUE_COUNT];
    logic        ring_ready_reg [QUEUE_COUNT];
    logic        ring_ready_next [QUEUE_COUNT];
    logic [31:0] desc_base_reg [QUEUE_COUNT];
    logic [31:0] desc_base_next [QUEUE_COUNT];
    logic [31:0] avail_base_reg [QUEUE_COUNT];
    logic [31:0] avail_base_next [QUEUE_COUNT];
    logic [31:0] used_base_reg [QUEUE_COUNT];
    logic [31:0] used_base_next [QUEUE_COUNT];
    logic [1:0]  irq_causes_reg, irq_causes_next;

    logic          qok;
    logic [QW-1:0] qidx;
    logic          feat_ok;
    logic [31:0]   read_word;
    logic [7:0]    status_value;

    assign busy      = 1'b0;
    assign cfg_ready = ~req_valid_reg;
    assign done      = done_reg;
    assign result    = rsp_reg;

    assign qok  = {1'b0, selected_queue_reg} < QUEUE_LIMIT;
    assign qidx = selected_queue_reg[QW-1:0];
    assign feat_ok = ((accepted_reg[0] & ~feat_low_reg) == 32'd0)
                  && ((accepted_reg[1] & ~feat_high_reg) == 32'd0)
                  && accepted_reg[1][0];
    assign status_value = req_reg.write_value[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
            done_reg      <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_type_reg <= DEVICE_TYPE_RESET;
            feat_low_reg    <= FEAT_LOW_RESET;
            feat_high_reg   <= FEAT_HIGH_RESET;
            queue_limit_reg <= QUEUE_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DEVICE_TYPE: device_type_reg <= cfg_data[7:0];
                CFG_FEAT_LOW:    feat_low_reg    <= cfg_data;
                CFG_FEAT_HIGH:   feat_high_reg   <= cfg_data;
                CFG_QUEUE_LIMIT: queue_limit_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        read_word = 32'd0;
        unique case (req_reg.reg_index)
            REG_MAGIC:     read_word = MAGIC_WORD;
            REG_VERSION:   read_word = MMIO_VERSION;
            REG_DEVICE_ID: read_word = {24'd0, device_type_reg};
            REG_DEV_FEAT:
            begin
                if (offer_page_reg == 32'd0)
                begin
                    read_word = feat_low_reg;
                end
                else if (offer_page_reg == 32'd1)
                begin
                    read_word = feat_high_reg;
                end
            end
            REG_DRV_FEAT:
            begin
                if (accept_page_reg[31:1] == 31'd0)
                begin
                    read_word = accepted_reg[accept_page_reg[0]];
                end
            end
            REG_QUEUE_MAX:   read_word = qok ? {16'd0, queue_limit_reg} : 32'd0;
            REG_QUEUE_SIZE:  read_word = qok ? {16'd0, ring_entries_reg[qidx]} : 32'd0;
            REG_QUEUE_READY: read_word = qok ? {31'd0, ring_ready_reg[qidx]} : 32'd0;
            REG_IRQ_STATUS:  read_word = {30'd0, irq_causes_reg};
            REG_STATUS:      read_word = {24'd0, device_status_reg};
            REG_DESC_BASE:   read_word = qok ? desc_base_reg[qidx] : 32'd0;
            REG_AVAIL_BASE:  read_word = qok ? avail_base_reg[qidx] : 32'd0;
            REG_USED_BASE:   read_word = qok ? used_base_reg[qidx] : 32'd0;
            default:         read_word = 32'd0;
        endcase
    end

    always_comb
    begin
        device_status_next  = device_status_reg;
        offer_page_next     = offer_page_reg;
        accepted_next       = accepted_reg;
        accept_page_next    = accept_page_reg;
        selected_queue_next = selected_queue_reg;
        ring_entries_next   = ring_entries_reg;
        ring_ready_next     = ring_ready_reg;
        desc_base_next      = desc_base_reg;
        avail_base_next     = avail_base_reg;
        used_base_next      = used_base_reg;
        irq_causes_next     = irq_causes_reg;
        rsp_next            = '0;

        if (req_valid_reg)
        begin
            unique case (req_reg.cmd)
                CMD_READ: rsp_next.read_value = read_word;
                CMD_WRITE:
                begin
                    unique case (req_reg.reg_index)
                        REG_DEV_FEAT_SEL: offer_page_next = req_reg.write_value;
                        REG_DRV_FEAT:
                        begin
                            if (accept_page_reg[31:1] == 31'd0)
                            begin
                                accepted_next[accept_page_reg[0]] = req_reg.write_value;
                            end
                        end
                        REG_DRV_FEAT_SEL: accept_page_next = req_reg.write_value;
                        REG_QUEUE_SEL: selected_queue_next = req_reg.write_value[15:0];
                        REG_QUEUE_SIZE:
                        begin
                            if (qok)
                            begin
                                ring_entries_next[qidx] = req_reg.write_value[15:0];
                            end
                        end
                        REG_QUEUE_READY:
                        begin
                            if (qok)
                            begin
                                ring_ready_next[qidx] = req_reg.write_value[0];
                            end
                        end
                        REG_QUEUE_NOTIFY:
                        begin
                            rsp_next.notify_valid = 1'b1;
                            rsp_next.notify_queue = req_reg.write_value[15:0];
                        end
                        REG_IRQ_ACK:
                        begin
                            irq_causes_next = irq_causes_reg & ~req_reg.write_value[1:0];
                        end
                        REG_STATUS:
                        begin
                            if (status_value == 8'd0)
                            begin
                                device_status_next  = 8'd0;
                                offer_page_next     = 32'd0;
                                accepted_next[0]    = 32'd0;
                                accepted_next[1]    = 32'd0;
                                accept_page_next    = 32'd0;
                                selected_queue_next = 16'd0;
                                irq_causes_next     = 2'd0;
                                for (int i = 0; i < QUEUE_COUNT; i++)
                                begin
                                    ring_entries_next[i] = 16'd0;
                                    ring_ready_next[i]   = 1'b0;
                                    desc_base_next[i]    = 32'd0;
                                    avail_base_next[i]   = 32'd0;
                                    used_base_next[i]    = 32'd0;
                                end
                            end
                            else
                            begin
                                device_status_next = status_value;
                                if (!feat_ok)
                                begin
                                    device_status_next[STATUS_FEATURES_OK_BIT] = 1'b0;
                                end
                            end
                        end
                        REG_DESC_BASE:
                        begin
                            if (qok)
                            begin
                                desc_base_next[qidx] = req_reg.write_value;
                            end
                        end
                        REG_AVAIL_BASE:
                        begin
                            if (qok)
                            begin
                                avail_base_next[qidx] = req_reg.write_value;
                            end
                        end
                        REG_USED_BASE:
                        begin
                            if (qok)
                            begin
                                used_base_next[qidx] = req_reg.write_value;
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_EVENT: irq_causes_next = irq_causes_reg | req_reg.write_value[1:0];
                default: ;
            endcase
        end

        rsp_next.irq_line = |irq_causes_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_status_reg  <= 8'd0;
            offer_page_reg     <= 32'd0;
            accepted_reg[0]    <= 32'd0;
            accepted_reg[1]    <= 32'd0;
            accept_page_reg    <= 32'd0;
            selected_queue_reg <= 16'd0;
            irq_causes_reg     <= 2'd0;
            for (int i = 0; i < QUEUE_COUNT; i++)
            begin
                ring_entries_reg[i] <= 16'd0;
                ring_ready_reg[i]   <= 1'b0;
                desc_base_reg[i]    <= 32'd0;
                avail_base_reg[i]   <= 32'd0;
                used_base_reg[i]    <= 32'd0;
            end
        end
        else
        begin
            device_status_reg  <= device_status_next;
            offer_page_reg     <= offer_page_next;
            accepted_reg       <= accepted_next;
            accept_page_reg    <= accept_page_next;
            selected_queue_reg <= selected_queue_next;
            irq_causes_reg     <= irq_causes_next;
            ring_entries_reg   <= ring_entries_next;
            ring_ready_reg     <= ring_ready_next;
            desc_base_reg      <= desc_base_next;
            avail_base_reg     <= avail_base_next;
            used_base_reg      <= used_base_next;
        end
    end

    // Every registered request yields exactly one result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(req_valid_reg))
        else $error("result strobe does not follow the registered request");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.irq_line == (irq_causes_reg != 2'd0)))
        else $error("irq_line disagrees with the interrupt status");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.notify_valid) |-> (result.read_value == 32'd0))
        else $error("notify result carries read data");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && req_reg.cmd == CMD_WRITE && req_reg.reg_index == REG_STATUS
            && req_reg.write_value[7:0] == 8'd0)
        |=> (device_status_reg == 8'd0 && irq_causes_reg == 2'd0
            && selected_queue_reg == 16'd0))
        else $error("status reset did not clear the transport state");

endmodule

/* tb/vmt_reg_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmt_reg_checker
// Watches the request, result and configuration channels of the virtio MMIO
// register block, keeps its own copy of the register state, predicts the
// result of every accepted request and compares the results in order.
// ----------------------------------------------------------------------------
module vmt_reg_checker
    import vmt_pkg::*;
#(
    parameter int QUEUE_COUNT = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  req_t        request,
    input  logic        done,
    input  rsp_t        result,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);

    logic [7:0]  dev_type;
    logic [31:0] feat_low;
    logic [31:0] feat_high;
    logic [15:0] queue_limit;

    logic [7:0]  dev_status;
    logic [31:0] offer_sel;
    logic [31:0] drv_feat [2];
    logic [31:0] accept_sel;
    logic [15:0] queue_sel;
    logic [15:0] q_size [QUEUE_COUNT];
    logic        q_ready [QUEUE_COUNT];
    logic [31:0] q_desc [QUEUE_COUNT];
    logic [31:0] q_avail [QUEUE_COUNT];
    logic [31:0] q_used [QUEUE_COUNT];
    logic [1:0]  irq_pending;

    rsp_t expected_rsp_q[$];
    int   error_count;

    assign mismatches = error_count;

    function automatic void clear_regs();
        dev_status  = '0;
        offer_sel   = '0;
        drv_feat[0] = '0;
        drv_feat[1] = '0;
        accept_sel  = '0;
        queue_sel   = '0;
        irq_pending = '0;
        for (int i = 0; i < QUEUE_COUNT; i++)
        begin
            q_size[i]  = '0;
            q_ready[i] = 1'b0;
            q_desc[i]  = '0;
            q_avail[i] = '0;
            q_used[i]  = '0;
        end
    endfunction

    function automatic rsp_t predict_access(req_t r);
        rsp_t       rsp;
        logic       q_ok;
        int         q;
        logic [7:0] st;
        rsp  = '0;
        q_ok = queue_sel < QUEUE_COUNT;
        q    = q_ok ? int'(queue_sel) : 0;
        case (r.cmd)
            CMD_READ:
            begin
                case (r.reg_index)
                    REG_MAGIC:       rsp.read_value = MAGIC_WORD;
                    REG_VERSION:     rsp.read_value = MMIO_VERSION;
                    REG_DEVICE_ID:   rsp.read_value = {24'd0, dev_type};
                    REG_DEV_FEAT:
                        rsp.read_value = (offer_sel == 32'd0) ? feat_low :
                                         (offer_sel == 32'd1) ? feat_high : 32'd0;
                    REG_DRV_FEAT:
                        if (accept_sel < 32'd2)
                            rsp.read_value = drv_feat[accept_sel[0]];
                    REG_QUEUE_MAX:   if (q_ok) rsp.read_value = {16'd0, queue_limit};
                    REG_QUEUE_SIZE:  if (q_ok) rsp.read_value = {16'd0, q_size[q]};
                    REG_QUEUE_READY: if (q_ok) rsp.read_value = {31'd0, q_ready[q]};
                    REG_IRQ_STATUS:  rsp.read_value = {30'd0, irq_pending};
                    REG_STATUS:      rsp.read_value = {24'd0, dev_status};
                    REG_DESC_BASE:   if (q_ok) rsp.read_value = q_desc[q];
                    REG_AVAIL_BASE:  if (q_ok) rsp.read_value = q_avail[q];
                    REG_USED_BASE:   if (q_ok) rsp.read_value = q_used[q];
                    default:         ;
                endcase
            end
            CMD_WRITE:
            begin
                case (r.reg_index)
                    REG_DEV_FEAT_SEL: offer_sel = r.write_value;
                    REG_DRV_FEAT:
                        if (accept_sel < 32'd2)
                            drv_feat[accept_sel[0]] = r.write_value;
                    REG_DRV_FEAT_SEL: accept_sel = r.write_value;
                    REG_QUEUE_SEL:    queue_sel = r.write_value[15:0];
                    REG_QUEUE_SIZE:   if (q_ok) q_size[q] = r.write_value[15:0];
                    REG_QUEUE_READY:  if (q_ok) q_ready[q] = r.write_value[0];
                    REG_QUEUE_NOTIFY:
                    begin
                        rsp.notify_valid = 1'b1;
                        rsp.notify_queue = r.write_value[15:0];
                    end
                    REG_IRQ_ACK:      irq_pending = irq_pending & ~r.write_value[1:0];
                    REG_STATUS:
                    begin
                        st = r.write_value[7:0];
                        if (st == 8'd0)
                        begin
                            clear_regs();
                        end
                        else
                        begin
                            // The driver may only claim features the device offers,
                            // and version 1 must be among them.
                            if (st[STATUS_FEATURES_OK_BIT] &&
                                !(((drv_feat[0] & ~feat_low) == 32'd0) &&
                                  ((drv_feat[1] & ~feat_high) == 32'd0) &&
                                  drv_feat[1][0]))
                                st[STATUS_FEATURES_OK_BIT] = 1'b0;
                            dev_status = st;
                        end
                    end
                    REG_DESC_BASE:    if (q_ok) q_desc[q] = r.write_value;
                    REG_AVAIL_BASE:   if (q_ok) q_avail[q] = r.write_value;
                    REG_USED_BASE:    if (q_ok) q_used[q] = r.write_value;
                    default:          ;
                endcase
            end
            CMD_EVENT: irq_pending = irq_pending | r.write_value[1:0];
            default:   ;
        endcase
        rsp.irq_line = |irq_pending;
        return rsp;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            dev_type    = DEVICE_TYPE_RESET;
            feat_low    = FEAT_LOW_RESET;
            feat_high   = FEAT_HIGH_RESET;
            queue_limit = QUEUE_LIMIT_RESET;
            clear_regs();
            expected_rsp_q.delete();
            error_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (done !== 1'b0)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: result with no request waiting: %h", $time, result);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (result.read_value !== want.read_value ||
                        result.irq_line !== want.irq_line ||
                        result.notify_valid !== want.notify_valid ||
                        result.notify_queue !== want.notify_queue)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"%0t: result mismatch, expected/actual: ",
                                      "read_value %h/%h irq_line %b/%b ",
                                      "notify_valid %b/%b notify_queue %h/%h"},
                                     $time, want.read_value, result.read_value,
                                     want.irq_line, result.irq_line,
                                     want.notify_valid, result.notify_valid,
                                     want.notify_queue, result.notify_queue);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DEVICE_TYPE: dev_type = cfg_data[7:0];
                    CFG_FEAT_LOW:    feat_low = cfg_data;
                    CFG_FEAT_HIGH:   feat_high = cfg_data;
                    CFG_QUEUE_LIMIT: queue_limit = cfg_data[15:0];
                    default:         ;
                endcase
            end
            if (start && !busy)
                expected_rsp_q.push_back(predict_access(request));
            outstanding <= expected_rsp_q.size();
        end
    end

endmodule

/* tb/tb_virtio_mmio_transport_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_virtio_mmio_transport_regs
// Drives register reads, writes, device events and unused commands into the virtio MMIO
// register block in random bursts, mostly as driver bring-up sequences, over
// several device configurations, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_virtio_mmio_transport_regs;
    import vmt_pkg::*;

    localparam int         QUEUE_COUNT      = 8;
    localparam int         ITEMS_PER_CONFIG = 160;
    localparam int         CONFIG_PHASES    = 5;
    localparam logic [1:0] CMD_UNUSED       = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        request;
    logic        done;
    rsp_t        result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          mismatches;
    int          outstanding;

    logic [31:0] offer_low;
    logic [31:0] offer_high;
    logic [15:0] size_limit;
    int          burst_left;
    int          n_items;
    int          n_read;
    int          n_write;
    int          n_event;
    int          n_unused;
    int          n_notify;
    int          n_config;

    virtio_mmio_transport_regs #(
        .QUEUE_COUNT(QUEUE_COUNT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    vmt_reg_checker #(
        .QUEUE_COUNT(QUEUE_COUNT)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb_virtio_mmio_transport_regs failed");
        $finish;
    end

    function automatic req_t mk(logic [1:0] cmd, logic [4:0] idx, logic [31:0] val);
        req_t r;
        r.cmd         = cmd;
        r.reg_index   = idx;
        r.write_value = val;
        return r;
    endfunction

    task automatic issue_request(input req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        start   <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy);
        n_items++;
        case (r.cmd)
            CMD_READ:  n_read++;
            CMD_WRITE:
            begin
                n_write++;
                if (r.reg_index == REG_QUEUE_NOTIFY)
                    n_notify++;
            end
            CMD_EVENT: n_event++;
            default:   n_unused++;
        endcase
    endtask

    task automatic settle();
        int guard;
        guard      = 0;
        burst_left = 0;
        start <= 1'b0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (outstanding != 0 && guard < 2000);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [7:0] dev, input logic [31:0] lo,
                             input logic [31:0] hi, input logic [15:0] lim);
        settle();
        write_cfg(CFG_DEVICE_TYPE, {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0, dev});
        write_cfg(CFG_FEAT_LOW, lo);
        write_cfg(CFG_FEAT_HIGH, hi);
        write_cfg(CFG_QUEUE_LIMIT, {16'($urandom), lim});
        cfg_valid <= 1'b0;
        @(posedge clk);
        offer_low  = lo;
        offer_high = hi;
        size_limit = lim;
        n_config++;
    endtask

    function automatic logic [31:0] stray_bit();
        return ($urandom_range(0, 4) == 0) ? (32'h1 << $urandom_range(0, 31)) : 32'h0;
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   pick;
        pick    = $urandom_range(0, 99);
        r.cmd   = (pick < 40) ? CMD_READ : (pick < 85) ? CMD_WRITE :
                  (pick < 96) ? CMD_EVENT : CMD_UNUSED;
        r.reg_index   = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(18, 31))
                                                    : 5'($urandom_range(0, 17));
        r.write_value = $urandom;
        if (r.cmd == CMD_WRITE && $urandom_range(0, 3) != 0)
        begin
            case (r.reg_index)
                REG_DEV_FEAT_SEL, REG_DRV_FEAT_SEL:
                    r.write_value = $urandom_range(0, 2);
                REG_QUEUE_SEL:
                    r.write_value = $urandom_range(0, QUEUE_COUNT);
                REG_DRV_FEAT:
                    r.write_value = ($urandom & ($urandom_range(0, 1) ? offer_high : offer_low))
                                    | 32'($urandom_range(0, 1)) | stray_bit();
                REG_STATUS:
                    r.write_value = ($urandom_range(0, 7) == 0) ? 32'h0
                                    : (($urandom & 32'hFF) | 32'h8);
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic bring_up();
        logic [15:0] q;
        q = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(QUEUE_COUNT, 65535))
                                        : 16'($urandom_range(0, QUEUE_COUNT - 1));
        if ($urandom_range(0, 1))
            issue_request(mk(CMD_WRITE, REG_STATUS, 32'h0));
        issue_request(mk(CMD_WRITE, REG_STATUS, 32'h1));
        issue_request(mk(CMD_WRITE, REG_STATUS, 32'h3));
        issue_request(mk(CMD_READ, REG_MAGIC, $urandom));
        issue_request(mk(CMD_READ, REG_DEVICE_ID, $urandom));
        issue_request(mk(CMD_WRITE, REG_DEV_FEAT_SEL, 32'h0));
        issue_request(mk(CMD_READ, REG_DEV_FEAT, $urandom));
        issue_request(mk(CMD_WRITE, REG_DEV_FEAT_SEL, 32'h1));
        issue_request(mk(CMD_READ, REG_DEV_FEAT, $urandom));
        issue_request(mk(CMD_WRITE, REG_DRV_FEAT_SEL, 32'h0));
        issue_request(mk(CMD_WRITE, REG_DRV_FEAT, ($urandom & offer_low) | stray_bit()));
        issue_request(mk(CMD_WRITE, REG_DRV_FEAT_SEL, 32'h1));
        issue_request(mk(CMD_WRITE, REG_DRV_FEAT,
                         ($urandom & offer_high) | 32'h1 | stray_bit()));
        issue_request(mk(CMD_READ, REG_DRV_FEAT, $urandom));
        issue_request(mk(CMD_WRITE, REG_STATUS, 32'h0B));
        issue_request(mk(CMD_READ, REG_STATUS, $urandom));
        issue_request(mk(CMD_WRITE, REG_QUEUE_SEL, {16'($urandom), q}));
        issue_request(mk(CMD_READ, REG_QUEUE_MAX, $urandom));
        issue_request(mk(CMD_READ, REG_QUEUE_READY, $urandom));
        issue_request(mk(CMD_WRITE, REG_QUEUE_SIZE,
                         ($urandom_range(0, 3) == 0) ? $urandom
                                                     : 32'($urandom_range(0, size_limit))));
        issue_request(mk(CMD_WRITE, REG_DESC_BASE, $urandom));
        issue_request(mk(CMD_WRITE, REG_AVAIL_BASE, $urandom));
        issue_request(mk(CMD_WRITE, REG_USED_BASE, $urandom));
        issue_request(mk(CMD_WRITE, REG_QUEUE_READY, $urandom | 32'h1));
        issue_request(mk(CMD_READ, REG_QUEUE_SIZE, $urandom));
        issue_request(mk(CMD_READ, REG_DESC_BASE, $urandom));
        issue_request(mk(CMD_READ, REG_AVAIL_BASE, $urandom));
        issue_request(mk(CMD_READ, REG_USED_BASE, $urandom));
        issue_request(mk(CMD_WRITE, REG_STATUS, 32'h0F));
        issue_request(mk(CMD_WRITE, REG_QUEUE_NOTIFY, {16'($urandom), q}));
        issue_request(mk(CMD_EVENT, 5'($urandom), $urandom));
        issue_request(mk(CMD_READ, REG_IRQ_STATUS, $urandom));
        issue_request(mk(CMD_WRITE, REG_IRQ_ACK, $urandom));
        issue_request(mk(CMD_READ, REG_IRQ_STATUS, $urandom));
    endtask

    initial
    begin
        int target;
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_DEVICE_TYPE;
        cfg_data   = '0;
        offer_low  = FEAT_LOW_RESET;
        offer_high = FEAT_HIGH_RESET;
        size_limit = QUEUE_LIMIT_RESET;
        burst_left = 0;
        n_items    = 0;
        n_read     = 0;
        n_write    = 0;
        n_event    = 0;
        n_unused   = 0;
        n_notify   = 0;
        n_config   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_request(mk(CMD_READ, REG_MAGIC, 32'h0));
        issue_request(mk(CMD_READ, REG_VERSION, 32'h0));
        issue_request(mk(CMD_READ, REG_DEVICE_ID, 32'h0));
        issue_request(mk(CMD_READ, REG_DEV_FEAT, 32'h0));
        issue_request(mk(CMD_WRITE, REG_DEV_FEAT_SEL, 32'h1));
        issue_request(mk(CMD_READ, REG_DEV_FEAT, 32'h0));
        issue_request(mk(CMD_WRITE, REG_DEV_FEAT_SEL, 32'hFFFF_FFFF));
        issue_request(mk(CMD_READ, REG_DEV_FEAT, 32'hFFFF_FFFF));
        issue_request(mk(CMD_WRITE, REG_DRV_FEAT_SEL, 32'h1));
        issue_request(mk(CMD_WRITE, REG_DRV_FEAT, 32'h1));
        issue_request(mk(CMD_WRITE, REG_STATUS, 32'hFF));
        issue_request(mk(CMD_READ, REG_STATUS, 32'h0));
        issue_request(mk(CMD_WRITE, REG_MAGIC, 32'hFFFF_FFFF));
        issue_request(mk(CMD_READ, REG_IRQ_ACK, 32'h0));
        issue_request(mk(CMD_WRITE, REG_QUEUE_SEL, 32'hFFFF_FFFF));
        issue_request(mk(CMD_READ, REG_QUEUE_MAX, 32'h0));
        issue_request(mk(CMD_WRITE, REG_QUEUE_SEL, QUEUE_COUNT - 1));
        issue_request(mk(CMD_WRITE, REG_QUEUE_SIZE, 32'hFFFF_FFFF));
        issue_request(mk(CMD_READ, REG_QUEUE_SIZE, 32'h0));
        issue_request(mk(CMD_EVENT, REG_MAGIC, 32'hFFFF_FFFF));
        issue_request(mk(CMD_WRITE, REG_IRQ_ACK, 32'h1));
        issue_request(mk(CMD_READ, REG_IRQ_STATUS, 32'h0));
        issue_request(mk(CMD_WRITE, REG_QUEUE_NOTIFY, 32'hFFFF_FFFF));
        issue_request(mk(CMD_UNUSED, 5'h1F, 32'hFFFF_FFFF));
        issue_request(mk(CMD_WRITE, REG_STATUS, 32'h100));

        for (int p = 0; p < CONFIG_PHASES; p++)
        begin
            case (p)
                0:       ;
                1:       configure(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd32768);
                2:       configure(8'h00, 32'h0, 32'h0, 16'd0);
                default: configure(8'($urandom), $urandom, $urandom | 32'h1,
                                   16'($urandom_range(0, 32768)));
            endcase
            target = n_items + ITEMS_PER_CONFIG;
            while (n_items < target)
            begin
                if ($urandom_range(0, 39) == 0)
                    settle();
                if ($urandom_range(0, 7) == 0)
                    bring_up();
                else
                    issue_request(random_request());
            end
        end

        settle();
        $display("Sent %0d requests: %0d reads, %0d writes (%0d notifies), %0d events, %0d unused.",
                 n_items, n_read, n_write, n_notify, n_event, n_unused);
        $display("Used %0d device configurations, including all-ones and all-zero ones.",
                 n_config + 1);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_virtio_mmio_transport_regs passed");
        else
            $display("tb_virtio_mmio_transport_regs failed");
        $finish;
    end

endmodule

/* sim.f */
design/vmt_pkg.sv
design/virtio_mmio_transport_regs.sv
tb/vmt_reg_checker.sv
tb/tb_virtio_mmio_transport_regs.sv
